// ----- rtl/bbiou_pkg.sv -----
`default_nettype none
package bbiou_pkg;

  // Box coordinate width (unsigned Q12.4 at the default) and ratio fraction bits
  localparam int CoordBits     = 16;
  localparam int RatioFracBits = 16;

  // Corners in doubled units: 2*center +/- size, signed
  localparam int CornerW = CoordBits + 3;
  // Doubled sizes and per-axis overlap lengths
  localparam int SizeW   = CoordBits + 1;
  // Areas in doubled units squared
  localparam int AreaW   = 2 * SizeW;
  // Union can reach twice the largest area
  localparam int UnionW  = AreaW + 1;
  // Partial remainder stays below twice the divisor
  localparam int RemW    = UnionW + 1;
  // One integer bit plus the fraction bits
  localparam int QuotW   = RatioFracBits + 1;
  // Width of the ratio result field
  localparam int OutW    = 17;

  // Item moving through the divider chain
  typedef struct packed {
    logic [RemW-1:0]   rem;
    logic [UnionW-1:0] den;
    logic [QuotW-1:0]  quot;
    logic              empty;
  } div_t;

endpackage
`default_nettype wire

// ----- rtl/bbiou_geom.sv -----
`default_nettype none
module bbiou_geom (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [bbiou_pkg::CoordBits-1:0] a_center_x_i,
  input  wire logic [bbiou_pkg::CoordBits-1:0] a_center_y_i,
  input  wire logic [bbiou_pkg::CoordBits-1:0] a_width_i,
  input  wire logic [bbiou_pkg::CoordBits-1:0] a_height_i,
  input  wire logic [bbiou_pkg::CoordBits-1:0] b_center_x_i,
  input  wire logic [bbiou_pkg::CoordBits-1:0] b_center_y_i,
  input  wire logic [bbiou_pkg::CoordBits-1:0] b_width_i,
  input  wire logic [bbiou_pkg::CoordBits-1:0] b_height_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output bbiou_pkg::div_t                    out_o
);

  localparam int CW = bbiou_pkg::CornerW;
  localparam int SW = bbiou_pkg::SizeW;
  localparam int AW = bbiou_pkg::AreaW;
  localparam int UW = bbiou_pkg::UnionW;

  // Stage valids and load enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Stage 1: corners in doubled units and doubled sizes
  logic signed [CW-1:0] lax_d, hax_d, lbx_d, hbx_d, lay_d, hay_d, lby_d, hby_d;
  logic signed [CW-1:0] lax_q, hax_q, lbx_q, hbx_q, lay_q, hay_q, lby_q, hby_q;
  logic [SW-1:0] aw2_q, ah2_q, bw2_q, bh2_q;

  function automatic logic signed [CW-1:0] corner_lo(
    input logic [bbiou_pkg::CoordBits-1:0] c,
    input logic [bbiou_pkg::CoordBits-1:0] s
  );
    return $signed(CW'({c, 1'b0})) - $signed(CW'(s));
  endfunction

  function automatic logic signed [CW-1:0] corner_hi(
    input logic [bbiou_pkg::CoordBits-1:0] c,
    input logic [bbiou_pkg::CoordBits-1:0] s
  );
    return $signed(CW'({c, 1'b0})) + $signed(CW'(s));
  endfunction

  always_comb begin
    lax_d = corner_lo(a_center_x_i, a_width_i);
    hax_d = corner_hi(a_center_x_i, a_width_i);
    lbx_d = corner_lo(b_center_x_i, b_width_i);
    hbx_d = corner_hi(b_center_x_i, b_width_i);
    lay_d = corner_lo(a_center_y_i, a_height_i);
    hay_d = corner_hi(a_center_y_i, a_height_i);
    lby_d = corner_lo(b_center_y_i, b_height_i);
    hby_d = corner_hi(b_center_y_i, b_height_i);
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      lax_q <= lax_d;
      hax_q <= hax_d;
      lbx_q <= lbx_d;
      hbx_q <= hbx_d;
      lay_q <= lay_d;
      hay_q <= hay_d;
      lby_q <= lby_d;
      hby_q <= hby_d;
      aw2_q <= {a_width_i, 1'b0};
      ah2_q <= {a_height_i, 1'b0};
      bw2_q <= {b_width_i, 1'b0};
      bh2_q <= {b_height_i, 1'b0};
    end
  end

  // Stage 2: clamped overlap per axis and both box areas
  function automatic logic [SW-1:0] overlap(
    input logic signed [CW-1:0] la,
    input logic signed [CW-1:0] ha,
    input logic signed [CW-1:0] lb,
    input logic signed [CW-1:0] hb
  );
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] hi;
    logic signed [CW:0]   diff;
    lo   = (la > lb) ? la : lb;
    hi   = (ha < hb) ? ha : hb;
    diff = (CW+1)'(hi) - (CW+1)'(lo);
    return (diff > 0) ? SW'(diff) : '0;
  endfunction

  logic [SW-1:0] ovx_q, ovy_q;
  logic [AW-1:0] area_a2_q, area_b2_q;

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      ovx_q     <= overlap(lax_q, hax_q, lbx_q, hbx_q);
      ovy_q     <= overlap(lay_q, hay_q, lby_q, hby_q);
      area_a2_q <= AW'(aw2_q) * AW'(ah2_q);
      area_b2_q <= AW'(bw2_q) * AW'(bh2_q);
    end
  end

  // Stage 3: intersection area
  logic [AW-1:0] inter_q, area_a3_q, area_b3_q;

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      inter_q   <= AW'(ovx_q) * AW'(ovy_q);
      area_a3_q <= area_a2_q;
      area_b3_q <= area_b2_q;
    end
  end

  // Stage 4: union and the seed of the divider
  bbiou_pkg::div_t seed_q;
  logic [UW-1:0]   union_d;

  assign union_d = UW'(area_a3_q) + UW'(area_b3_q) - UW'(inter_q);

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      seed_q.rem   <= bbiou_pkg::RemW'(inter_q);
      seed_q.den   <= union_d;
      seed_q.quot  <= '0;
      // Union is at least the larger area, so it is zero only with both areas
      seed_q.empty <= (area_a3_q == '0) && (area_b3_q == '0);
    end
  end

  assign out_valid_o = v4_q;
  assign out_o       = seed_q;

endmodule
`default_nettype wire

// ----- rtl/bbiou_div_step.sv -----
`default_nettype none
module bbiou_div_step (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire bbiou_pkg::div_t in_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output bbiou_pkg::div_t      out_o
);

  localparam int RW = bbiou_pkg::RemW;
  localparam int QW = bbiou_pkg::QuotW;

  logic            valid_q;
  logic            en;
  logic            ge;
  logic [RW-1:0]   diff;
  bbiou_pkg::div_t step_d;
  bbiou_pkg::div_t step_q;

  assign en         = !valid_q || out_ready_i;
  assign in_ready_o = en;

  // One restoring step: compare, subtract, shift in the quotient bit
  always_comb begin
    ge          = in_i.rem >= RW'(in_i.den);
    diff        = ge ? (in_i.rem - RW'(in_i.den)) : in_i.rem;
    step_d.rem  = {diff[RW-2:0], 1'b0};
    step_d.den  = in_i.den;
    step_d.quot = {in_i.quot[QW-2:0], ge};
    step_d.empty = in_i.empty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      step_q <= step_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = step_q;

endmodule
`default_nettype wire

// ----- rtl/box_intersection_over_union.sv -----
// Pipeline: 4 geometry stages plus QuotW divider stages.
// Throughput: one item per cycle; each stage holds its item while the next is full.
// The divider retires one quotient bit per stage, so its depth sets the latency.
// Reset: rst_ni asynchronous, active low, clears all stage valid bits;
// data registers are not reset.
`default_nettype none
module box_intersection_over_union (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [bbiou_pkg::CoordBits-1:0] a_center_x_i,
  input  wire logic [bbiou_pkg::CoordBits-1:0] a_center_y_i,
  input  wire logic [bbiou_pkg::CoordBits-1:0] a_width_i,
  input  wire logic [bbiou_pkg::CoordBits-1:0] a_height_i,
  input  wire logic [bbiou_pkg::CoordBits-1:0] b_center_x_i,
  input  wire logic [bbiou_pkg::CoordBits-1:0] b_center_y_i,
  input  wire logic [bbiou_pkg::CoordBits-1:0] b_width_i,
  input  wire logic [bbiou_pkg::CoordBits-1:0] b_height_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [bbiou_pkg::OutW-1:0]           overlap_ratio_o,
  output logic                                 empty_union_o
);

  localparam int QW = bbiou_pkg::QuotW;

  logic            valid [QW+1];
  logic            ready [QW+1];
  bbiou_pkg::div_t item  [QW+1];

  // Corners, overlap, areas and union
  bbiou_geom u_geom (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .a_center_x_i (a_center_x_i),
    .a_center_y_i (a_center_y_i),
    .a_width_i    (a_width_i),
    .a_height_i   (a_height_i),
    .b_center_x_i (b_center_x_i),
    .b_center_y_i (b_center_y_i),
    .b_width_i    (b_width_i),
    .b_height_i   (b_height_i),
    .out_valid_o  (valid[0]),
    .out_ready_i  (ready[0]),
    .out_o        (item[0])
  );

  // Divider chain, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    bbiou_div_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[k]),
      .in_ready_o  (ready[k]),
      .in_i        (item[k]),
      .out_valid_o (valid[k+1]),
      .out_ready_i (ready[k+1]),
      .out_o       (item[k+1])
    );
  end

  assign ready[QW]  = out_ready_i;
  assign out_valid_o = valid[QW];

  // Force the ratio to zero for an empty union
  assign overlap_ratio_o = item[QW].empty ? '0 : bbiou_pkg::OutW'(item[QW].quot);
  assign empty_union_o   = item[QW].empty;

endmodule
`default_nettype wire

// ----- rtl/bbiou_checker.sv -----
`default_nettype none
module bbiou_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [bbiou_pkg::OutW-1:0] overlap_ratio_o,
  input wire logic                       empty_union_o
);

  localparam logic [bbiou_pkg::OutW:0] One = (bbiou_pkg::OutW+1)'(1) << bbiou_pkg::RatioFracBits;

  // An empty union always reports a zero ratio
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_union_o |-> overlap_ratio_o == '0)
    else $error("empty union with nonzero ratio");

  // The ratio never exceeds one
  a_ratio_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bbiou_pkg::OutW+1)'(overlap_ratio_o) <= One)
    else $error("ratio above one");

  // Input backpressure only when every stage is full and the output stalls
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while pipeline can advance");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(overlap_ratio_o) && $stable(empty_union_o))
    else $error("stalled result changed");

endmodule

bind box_intersection_over_union bbiou_checker u_checker (.*);
`default_nettype wire
